/* rtl/smf_pkg.sv */
`default_nettype none
package smf_pkg;

   localparam int PATTERN_MAX   = 32;
   localparam int CHAR_BITS     = 8;
   localparam int POSITION_BITS = 32;
   localparam int COUNT_BITS    = $clog2(PATTERN_MAX + 1);

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_TEXT    = 2'd1,
      OP_RESTART = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] char_value;
   } req_type;

   typedef struct packed {
      logic        match_found;
      logic [31:0] match_start;
      logic        pattern_overflow;
   } rsp_type;

   typedef struct packed {
      logic pattern_shift;
      logic text_shift;
   } cell_ctl_type;

endpackage
`default_nettype wire

/* rtl/substring_match_finder_core.sv */
`default_nettype none
// Exact substring search over a byte stream, overlapping matches included. Pattern bytes are
// appended one per load beat (up to 32; a load into a full pattern is dropped and flagged), and
// each text beat returns whether the pattern ends at that character and, if so, the 0-based
// start position modulo 2^32. Restart zeroes the text position; clear empties the pattern, and
// an empty pattern never matches. Every request beat yields exactly one response beat, presented
// in the cycle after acceptance. A new request is taken every cycle while the response register is
// empty or being drained; the cycle time is set by the combinational compare across the row of 32
// cells (each holding one pattern byte and one window byte) and its AND tree.
module substring_match_finder_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire smf_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output smf_pkg::rsp_type      rsp_data
);

   localparam int N = smf_pkg::PATTERN_MAX;

   logic                                accept;
   smf_pkg::op_type                     op;
   logic [smf_pkg::CHAR_BITS-1:0]       ch;
   smf_pkg::cell_ctl_type               ctl;

   logic [smf_pkg::COUNT_BITS-1:0]      pattern_count_ff, pattern_count_in;
   logic [smf_pkg::COUNT_BITS-1:0]      window_fill_ff, window_fill_in;
   logic [smf_pkg::POSITION_BITS-1:0]   text_count_ff, text_count_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   smf_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   logic [smf_pkg::COUNT_BITS-1:0]      fill_next;
   logic [smf_pkg::POSITION_BITS-1:0]   start_pos;
   logic                                pattern_full;

   logic [N-1:0][smf_pkg::CHAR_BITS-1:0] pattern_q;
   logic [N-1:0][smf_pkg::CHAR_BITS-1:0] text_q;
   logic [N-1:0]                         active;
   logic [N-1:0]                         hits;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign op        = smf_pkg::op_type'(req_data.operation);
   assign ch        = req_data.char_value[smf_pkg::CHAR_BITS-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign pattern_full      = (pattern_count_ff == smf_pkg::COUNT_BITS'(N));
   assign ctl.pattern_shift = accept && (op == smf_pkg::OP_LOAD) && !pattern_full;
   assign ctl.text_shift    = accept && (op == smf_pkg::OP_TEXT);

   // The pattern is kept newest-first, so cell j pairs pattern byte (count-1-j) with window byte j.
   for (genvar j = 0; j < N; j++) begin : g_cell
      logic [smf_pkg::CHAR_BITS-1:0] p_in;
      logic [smf_pkg::CHAR_BITS-1:0] t_in;
      if (j == 0) begin : g_head
         assign p_in = ch;
         assign t_in = ch;
      end else begin : g_body
         assign p_in = pattern_q[j-1];
         assign t_in = text_q[j-1];
      end
      assign active[j] = (smf_pkg::COUNT_BITS'(j) < pattern_count_ff);
      smf_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .pattern_in  (p_in),
         .text_in     (t_in),
         .active      (active[j]),
         .pattern_out (pattern_q[j]),
         .text_out    (text_q[j]),
         .hit         (hits[j])
      );
   end

   assign fill_next = (window_fill_ff == smf_pkg::COUNT_BITS'(N)) ? window_fill_ff
                                                                  : window_fill_ff + 1'b1;
   assign start_pos = text_count_ff - smf_pkg::POSITION_BITS'(pattern_count_ff) + 1'b1;

   always_comb begin
      pattern_count_in = pattern_count_ff;
      window_fill_in   = window_fill_ff;
      text_count_in    = text_count_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_data_in      = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         unique case (op)
            smf_pkg::OP_LOAD: begin
               if (pattern_full) begin
                  rsp_data_in.pattern_overflow = 1'b1;
               end else begin
                  pattern_count_in = pattern_count_ff + 1'b1;
               end
            end
            smf_pkg::OP_TEXT: begin
               window_fill_in = fill_next;
               text_count_in  = text_count_ff + 1'b1;
               if ((pattern_count_ff != '0) && (&hits) && (fill_next >= pattern_count_ff)) begin
                  rsp_data_in.match_found = 1'b1;
                  rsp_data_in.match_start = start_pos[31:0];
               end
            end
            smf_pkg::OP_RESTART: begin
               window_fill_in = '0;
               text_count_in  = '0;
            end
            smf_pkg::OP_CLEAR: begin
               pattern_count_in = '0;
            end
            default: begin
               rsp_data_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_count_ff <= '0;
         window_fill_ff   <= '0;
         text_count_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         pattern_count_ff <= pattern_count_in;
         window_fill_ff   <= window_fill_in;
         text_count_ff    <= text_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

/* rtl/smf_cell.sv */
`default_nettype none
module smf_cell (
   input  wire                                clock,
   input  wire smf_pkg::cell_ctl_type         ctl,
   input  wire logic [smf_pkg::CHAR_BITS-1:0] pattern_in,
   input  wire logic [smf_pkg::CHAR_BITS-1:0] text_in,
   input  wire logic                          active,
   output logic      [smf_pkg::CHAR_BITS-1:0] pattern_out,
   output logic      [smf_pkg::CHAR_BITS-1:0] text_out,
   output logic                               hit
);

   logic [smf_pkg::CHAR_BITS-1:0] pattern_ff;
   logic [smf_pkg::CHAR_BITS-1:0] text_ff;

   // The compare looks at the character this cell takes on the coming text shift.
   assign hit         = !active || (pattern_ff == text_in);
   assign pattern_out = pattern_ff;
   assign text_out    = text_ff;

   always_ff @(posedge clock) begin
      if (ctl.pattern_shift) begin
         pattern_ff <= pattern_in;
      end
      if (ctl.text_shift) begin
         text_ff <= text_in;
      end
   end

endmodule
`default_nettype wire
